// ===== rtl/bfua_pkg.sv =====
// shared constants, types and codes of the best-fit unit allocator
`default_nettype none

package bfua_pkg;

  localparam int UNITS    = 1024;
  localparam int ADDR_W   = $clog2(UNITS);
  localparam int CNT_W    = $clog2(UNITS + 1);
  localparam int SCAN_W   = $clog2(UNITS + 2);
  localparam int ID_W     = 8;
  localparam int REQ_W    = 11;
  localparam int STATUS_W = 3;
  localparam int START_W  = 10;
  localparam int CHG_W    = 11;
  localparam int ENTRY_W  = ID_W + 1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_SIZE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_EVAL,
    S_FILL,
    S_PUSH
  } state_t;

  // one step of the shared run/count unit
  typedef struct packed {
    logic              clear;
    logic              step;
    logic              count_mode;
    logic              used;
    logic [ADDR_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] best_start;
    logic [CNT_W-1:0]  count;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/bfua_if.sv =====
// request and response channel interfaces
`default_nettype none

interface bfua_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [bfua_pkg::ID_W-1:0]  process_id;
  logic [bfua_pkg::REQ_W-1:0] request_size;

  modport source (output valid, output operation, output process_id,
                  output request_size, input ready);
  modport sink   (input valid, input operation, input process_id,
                  input request_size, output ready);
endinterface

interface bfua_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfua_pkg::STATUS_W-1:0] status;
  logic [bfua_pkg::START_W-1:0]  start_unit;
  logic [bfua_pkg::CHG_W-1:0]    units_changed;

  modport source (output valid, output status, output start_unit,
                  output units_changed, input ready);
  modport sink   (input valid, input status, input start_unit,
                  input units_changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfua_map.sv =====
// owner map memory: one write port, one registered read port
`default_nettype none

module bfua_map (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [bfua_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [bfua_pkg::ENTRY_W-1:0]  wdata,
  input  wire logic [bfua_pkg::ADDR_W-1:0]   raddr,
  output logic      [bfua_pkg::ENTRY_W-1:0]  rdata_r
);

  logic [bfua_pkg::ENTRY_W-1:0] mem [bfua_pkg::UNITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bfua_scan.sv =====
// shared run tracker: free-run length, best-fit compare, match counter
`default_nettype none

module bfua_scan (
  input  wire logic                        clk,
  input  wire bfua_pkg::scan_ctl_t         ctl,
  input  wire logic [bfua_pkg::CNT_W-1:0]  size,
  output bfua_pkg::scan_res_t              res
);

  logic [bfua_pkg::CNT_W-1:0]  run_len_r,    run_len_nxt;
  logic [bfua_pkg::ADDR_W-1:0] run_start_r,  run_start_nxt;
  logic [bfua_pkg::ADDR_W-1:0] best_start_r, best_start_nxt;
  logic [bfua_pkg::SCAN_W-1:0] best_size_r,  best_size_nxt;
  logic                        found_r,      found_nxt;
  logic                        fits;

  assign fits = (run_len_r >= size) &&
                (bfua_pkg::SCAN_W'(run_len_r) < best_size_r);

  always_comb begin
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    found_nxt      = found_r;
    if (ctl.clear) begin
      run_len_nxt    = '0;
      run_start_nxt  = '0;
      best_start_nxt = '0;
      best_size_nxt  = bfua_pkg::SCAN_W'(bfua_pkg::UNITS + 1);
      found_nxt      = 1'b0;
    end else if (ctl.step) begin
      if (ctl.count_mode) begin
        // release pass: count matching entries
        if (ctl.used) begin
          run_len_nxt = run_len_r + 1'b1;
        end
      end else if (!ctl.used) begin
        if (run_len_r == '0) begin
          run_start_nxt = ctl.idx;
        end
        run_len_nxt = run_len_r + 1'b1;
      end else begin
        // end of a free run
        if (fits) begin
          best_size_nxt  = bfua_pkg::SCAN_W'(run_len_r);
          best_start_nxt = run_start_r;
          found_nxt      = 1'b1;
        end
        run_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    best_start_r <= best_start_nxt;
    best_size_r  <= best_size_nxt;
    found_r      <= found_nxt;
  end

  assign res.found      = found_r;
  assign res.best_start = best_start_r;
  assign res.count      = run_len_r;

endmodule

`default_nettype wire

// ===== rtl/best_fit_unit_allocator.sv =====
// best-fit contiguous unit allocator: sequencer and result register
//
// in_ch carries requests (operation, process_id, request_size) and out_ch
// carries one result per request (status, start_unit, units_changed). Both
// are valid/ready channels; a transaction happens when valid and ready are
// high at a rising edge of clk. One request is worked on at a time.
// After rst_n is released the owner map is cleared one unit per cycle,
// all UNITS (1024) units, with in_ch.ready low.
// An allocate walks the map through the single read port with the shared
// run unit, then writes the chosen run one unit per cycle. A release walks
// the map once, freeing matches as it goes. A bad size skips the walk and
// goes straight to the result.
// The result sits in an output register; in_ch.ready returns as soon as the
// result is loaded, so the next request can run while out_ch is stalled. If
// that next result finishes while the previous one is still not taken, the
// block holds it and waits.
`default_nettype none

module best_fit_unit_allocator (
  input  wire logic     clk,
  input  wire logic     rst_n,
  bfua_req_if.sink      in_ch,
  bfua_rsp_if.source    out_ch
);

  bfua_pkg::state_t            state_r, state_nxt;
  logic [bfua_pkg::SCAN_W-1:0] cnt_r, cnt_nxt;
  logic                        op_r, op_nxt;
  logic [bfua_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [bfua_pkg::CNT_W-1:0]  size_r, size_nxt;
  bfua_pkg::status_t           res_status_r, res_status_nxt;
  logic [bfua_pkg::START_W-1:0] res_start_r, res_start_nxt;
  logic [bfua_pkg::CHG_W-1:0]  res_chg_r, res_chg_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bfua_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bfua_pkg::START_W-1:0] out_start_r, out_start_nxt;
  logic [bfua_pkg::CHG_W-1:0]  out_chg_r, out_chg_nxt;

  logic                         map_we;
  logic [bfua_pkg::ADDR_W-1:0]  map_waddr;
  logic [bfua_pkg::ENTRY_W-1:0] map_wdata;
  logic [bfua_pkg::ADDR_W-1:0]  map_raddr;
  logic [bfua_pkg::ENTRY_W-1:0] map_rdata;

  bfua_pkg::scan_ctl_t         scan_ctl;
  bfua_pkg::scan_res_t         scan_res;

  logic [bfua_pkg::ADDR_W-1:0] proc_idx;
  logic                        in_map;
  logic                        bad_size;
  logic                        hit;

  bfua_map u_map (
    .clk     (clk),
    .we      (map_we),
    .waddr   (map_waddr),
    .wdata   (map_wdata),
    .raddr   (map_raddr),
    .rdata_r (map_rdata)
  );

  bfua_scan u_scan (
    .clk  (clk),
    .ctl  (scan_ctl),
    .size (size_r),
    .res  (scan_res)
  );

  // read data arrives in the cycle after its address
  assign proc_idx  = bfua_pkg::ADDR_W'(cnt_r - 1'b1);
  assign in_map    = cnt_r <= bfua_pkg::SCAN_W'(bfua_pkg::UNITS);
  assign map_raddr = cnt_r[bfua_pkg::ADDR_W-1:0];
  assign hit       = map_rdata == {1'b1, id_r};
  assign bad_size  = (in_ch.request_size == '0) ||
                     (32'(in_ch.request_size) > bfua_pkg::UNITS);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_chg_nxt    = res_chg_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_chg_nxt    = out_chg_r;
    map_we         = 1'b0;
    map_waddr      = proc_idx;
    map_wdata      = '0;
    scan_ctl       = '0;
    scan_ctl.idx   = proc_idx;
    in_ch.ready    = 1'b0;

    unique case (state_r)
      bfua_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = cnt_r[bfua_pkg::ADDR_W-1:0];
        if (cnt_r == bfua_pkg::SCAN_W'(bfua_pkg::UNITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = bfua_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfua_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt         = in_ch.operation;
          id_nxt         = in_ch.process_id;
          size_nxt       = bfua_pkg::CNT_W'(in_ch.request_size);
          cnt_nxt        = '0;
          scan_ctl.clear = 1'b1;
          if (in_ch.operation == bfua_pkg::OP_RELEASE) begin
            state_nxt = bfua_pkg::S_REL;
          end else if (bad_size) begin
            res_status_nxt = bfua_pkg::ST_BAD_SIZE;
            res_start_nxt  = '0;
            res_chg_nxt    = '0;
            state_nxt      = bfua_pkg::S_PUSH;
          end else begin
            state_nxt = bfua_pkg::S_SCAN;
          end
        end
      end
      bfua_pkg::S_SCAN: begin
        if (cnt_r != '0) begin
          scan_ctl.step = 1'b1;
          // the slot past the last unit closes the final run
          scan_ctl.used = in_map ? map_rdata[bfua_pkg::ENTRY_W-1] : 1'b1;
        end
        if (cnt_r == bfua_pkg::SCAN_W'(bfua_pkg::UNITS + 1)) begin
          state_nxt = bfua_pkg::S_EVAL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfua_pkg::S_REL: begin
        if (cnt_r != '0) begin
          scan_ctl.step       = 1'b1;
          scan_ctl.count_mode = 1'b1;
          scan_ctl.used       = hit;
          map_we              = hit;
        end
        if (cnt_r == bfua_pkg::SCAN_W'(bfua_pkg::UNITS)) begin
          state_nxt = bfua_pkg::S_EVAL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfua_pkg::S_EVAL: begin
        cnt_nxt       = '0;
        res_start_nxt = '0;
        res_chg_nxt   = '0;
        state_nxt     = bfua_pkg::S_PUSH;
        if (op_r == bfua_pkg::OP_ALLOC) begin
          if (scan_res.found) begin
            state_nxt = bfua_pkg::S_FILL;
          end else begin
            res_status_nxt = bfua_pkg::ST_NO_FIT;
          end
        end else if (scan_res.count == '0) begin
          res_status_nxt = bfua_pkg::ST_NOT_FOUND;
        end else begin
          res_status_nxt = bfua_pkg::ST_RELEASED;
          res_chg_nxt    = bfua_pkg::CHG_W'(scan_res.count);
        end
      end
      bfua_pkg::S_FILL: begin
        map_we    = 1'b1;
        map_waddr = scan_res.best_start + cnt_r[bfua_pkg::ADDR_W-1:0];
        map_wdata = {1'b1, id_r};
        if (cnt_r + 1'b1 == bfua_pkg::SCAN_W'(size_r)) begin
          res_status_nxt = bfua_pkg::ST_ALLOCATED;
          res_start_nxt  = bfua_pkg::START_W'(scan_res.best_start);
          res_chg_nxt    = bfua_pkg::CHG_W'(size_r);
          state_nxt      = bfua_pkg::S_PUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfua_pkg::S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_chg_nxt    = res_chg_r;
          state_nxt      = bfua_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfua_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfua_pkg::S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_chg_r    <= res_chg_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_chg_r    <= out_chg_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.start_unit    = out_start_r;
  assign out_ch.units_changed = out_chg_r;

endmodule

`default_nettype wire

// ===== rtl/bfua_chk.sv =====
// port-level checker for the allocator, bound to the top level
`default_nettype none

module bfua_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bfua_pkg::STATUS_W-1:0] out_status,
  input wire logic [bfua_pkg::START_W-1:0]  out_start_unit,
  input wire logic [bfua_pkg::CHG_W-1:0]    out_units_changed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_start_unit) &&
      $stable(out_units_changed))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bfua_pkg::ST_NO_FIT ||
                  out_status == bfua_pkg::ST_NOT_FOUND ||
                  out_status == bfua_pkg::ST_BAD_SIZE) |->
      out_start_unit == '0 && out_units_changed == '0)
    else $error("failed request reports units");

  a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bfua_pkg::ST_RELEASED |->
      out_start_unit == '0 && out_units_changed != '0)
    else $error("bad release result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bfua_pkg::ST_BAD_SIZE)
    else $error("undefined status code");

endmodule

bind best_fit_unit_allocator bfua_chk u_bfua_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_start_unit    (out_ch.start_unit),
  .out_units_changed (out_ch.units_changed)
);

`default_nettype wire
